### src/assert_macros.svh
// assertion macros used by the rtl top level of the rollaway risk block
// uses clk and arst_n of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

### src/rrsm_pkg.sv
// types, codes and reset values of the rollaway risk state machine
// no dependencies
`timescale 1ns / 1ps

package rrsm_pkg;

	// register indexes
	localparam logic [1:0] CFG_SPEED_THR  = 2'd0;
	localparam logic [1:0] CFG_ACCEL_THR  = 2'd1;
	localparam logic [1:0] CFG_WARN_DELAY = 2'd2;

	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] SPEED_THR_RESET  = 16'd100;
	localparam logic [14:0] ACCEL_THR_RESET  = 15'd2;
	localparam logic [15:0] WARN_DELAY_RESET = 16'd2000;

	// driver codes
	localparam logic [1:0] DRV_ABSENT = 2'd0;
	localparam logic [1:0] DRV_SEATED = 2'd1;

	// gear codes
	localparam logic [1:0] GEAR_P = 2'd0;
	localparam logic [1:0] GEAR_R = 2'd1;
	localparam logic [1:0] GEAR_N = 2'd2;
	localparam logic [1:0] GEAR_D = 2'd3;

	// actuator feedback codes
	localparam logic [1:0] ACT_HOLD  = 2'd1;
	localparam logic [1:0] ACT_FORCE = 2'd2;

	typedef enum logic [2:0] {
		LVL_NORMAL = 3'd0,
		LVL_WARN1  = 3'd1,
		LVL_WARN2  = 3'd2,
		LVL_DBRAKE = 3'd3,
		LVL_RBRAKE = 3'd4,
		LVL_RWARN  = 3'd5,
		LVL_RBRK   = 3'd6
	} level_t;

	typedef enum logic [1:0] {
		BRK_RELEASE = 2'd0,
		BRK_HOLD    = 2'd1,
		BRK_FORCE   = 2'd2
	} brake_t;

	typedef struct packed {
		logic [1:0]  driver;
		logic [1:0]  gear;
		logic        door_is_open;
		logic [15:0] speed;
		logic signed [15:0] accel_long;
		logic signed [15:0] accel_lat;
		logic        actuator_alive;
		logic [1:0]  actuator_brake;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0] risk;
		logic [1:0] brake_command;
	} out_word_t;

	typedef struct packed {
		logic [15:0] speed_thr;
		logic [14:0] accel_thr;
		logic [15:0] warn_delay;
	} cfg_t;

	typedef struct packed {
		logic        timing;
		logic [31:0] since;
	} door_t;

	function automatic logic is_auto_brake(input level_t lvl);
		return (lvl == LVL_DBRAKE) || (lvl == LVL_RBRAKE) || (lvl == LVL_RBRK);
	endfunction

endpackage

### src/rrsm_step.sv
// next risk level, brake command and door timer for one sample word
// depends on rrsm_pkg
`timescale 1ns / 1ps

module rrsm_step (
	input  rrsm_pkg::in_word_t word,
	input  rrsm_pkg::cfg_t     cfg,
	input  rrsm_pkg::level_t   level,
	input  rrsm_pkg::door_t    door,
	output rrsm_pkg::level_t   level_next,
	output rrsm_pkg::door_t    door_next,
	output rrsm_pkg::brake_t   brake
);
	import rrsm_pkg::*;

	logic               moving;
	logic signed [16:0] ax;
	logic signed [16:0] ay;
	logic signed [16:0] thr_pos;
	logic signed [16:0] thr_neg;
	logic [31:0]        open_ms;
	logic               seated;
	logic               absent;
	logic               door_ajar;
	logic               g_p;
	logic               g_r;
	logic               g_n;
	logic               g_d;
	logic               g_dr;
	logic               engaged;

	// motion from speed or either acceleration magnitude, only with live feedback
	always_comb begin
		ax      = {word.accel_long[15], word.accel_long};
		ay      = {word.accel_lat[15], word.accel_lat};
		thr_pos = {2'b00, cfg.accel_thr};
		thr_neg = 17'sd0 - thr_pos;
		moving  = word.actuator_alive &&
			((word.speed >= cfg.speed_thr) ||
			 (ax >= thr_pos) || (ax <= thr_neg) ||
			 (ay >= thr_pos) || (ay <= thr_neg));
	end

	// door-open timer: latch on opening, clear on closing
	always_comb begin
		door_next = door;
		if (word.door_is_open && !door.timing) begin
			door_next.timing = 1'b1;
			door_next.since  = word.now_ms;
		end else if (!word.door_is_open) begin
			door_next.timing = 1'b0;
			door_next.since  = '0;
		end
		open_ms = door_next.timing ? (word.now_ms - door_next.since) : '0;
	end

	// priority rules, then per-level transitions
	always_comb begin
		seated    = (word.driver == DRV_SEATED);
		absent    = (word.driver == DRV_ABSENT);
		door_ajar = word.door_is_open;
		g_p       = (word.gear == GEAR_P);
		g_r       = (word.gear == GEAR_R);
		g_n       = (word.gear == GEAR_N);
		g_d       = (word.gear == GEAR_D);
		g_dr      = g_d || g_r;

		if (g_p && !is_auto_brake(level)) begin
			level_next = LVL_NORMAL;
		end else if (seated && !door_ajar) begin
			level_next = LVL_NORMAL;
		end else if (g_d && absent) begin
			level_next = LVL_DBRAKE;
		end else if (g_r && absent) begin
			level_next = LVL_RBRAKE;
		end else if (g_n && moving && absent) begin
			level_next = LVL_RBRK;
		end else if (g_n && door_ajar) begin
			level_next = LVL_RWARN;
		end else begin
			case (level)
				LVL_NORMAL: begin
					level_next = (g_dr && door_ajar) ? LVL_WARN1 : LVL_NORMAL;
				end
				LVL_WARN1: begin
					if (!door_ajar || (!g_dr && !g_n))
						level_next = LVL_NORMAL;
					else if (open_ms >= {16'd0, cfg.warn_delay})
						level_next = LVL_WARN2;
					else
						level_next = LVL_WARN1;
				end
				LVL_WARN2: begin
					level_next = door_ajar ? LVL_WARN2 : LVL_NORMAL;
				end
				LVL_DBRAKE: level_next = LVL_DBRAKE;
				LVL_RBRAKE: level_next = LVL_RBRAKE;
				LVL_RWARN: begin
					if (!door_ajar)
						level_next = LVL_NORMAL;
					else if (g_dr)
						level_next = LVL_WARN1;
					else if (moving && absent)
						level_next = LVL_RBRK;
					else
						level_next = LVL_RWARN;
				end
				LVL_RBRK: level_next = LVL_RBRK;
				default: level_next = LVL_NORMAL;
			endcase
		end
	end

	// brake command from the new level and actuator feedback
	always_comb begin
		engaged = word.actuator_alive &&
			((word.actuator_brake == ACT_HOLD) || (word.actuator_brake == ACT_FORCE));
		if (!is_auto_brake(level_next))
			brake = BRK_RELEASE;
		else if (!engaged)
			brake = BRK_FORCE;
		else
			brake = BRK_HOLD;
	end

endmodule

### src/rollaway_risk_state_machine_top.sv
// top level of the rollaway risk state machine: registers, word stages, state
// depends on rrsm_pkg, rrsm_step and assert_macros.svh
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid / in_stall   | in_word  (vehicle sample)
//   out     | output    | out_valid / out_stall | out_word (risk level, brake)
//   cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// one word per cycle while out_stall is low; a sample passes the input register,
// then the result register, from acceptance to result
// arst_n clears the level, door timer and both valid flags and loads the config registers with their reset values
// a stalled result holds the input register, which then stalls the input side
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rollaway_risk_state_machine_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rrsm_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output rrsm_pkg::out_word_t out_word,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [rrsm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rrsm_pkg::*;

	cfg_t     cfg_q;
	in_word_t word_s1;
	logic     valid_s1;
	logic     valid_s2;
	level_t   level_q;
	door_t    door_q;
	level_t   level_next;
	door_t    door_next;
	brake_t   brake;
	logic     adv_s1;
	logic     load_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_thr  <= SPEED_THR_RESET;
			cfg_q.accel_thr  <= ACCEL_THR_RESET;
			cfg_q.warn_delay <= WARN_DELAY_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SPEED_THR:  cfg_q.speed_thr  <= cfg_data;
				CFG_ACCEL_THR:  cfg_q.accel_thr  <= cfg_data[14:0];
				CFG_WARN_DELAY: cfg_q.warn_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage flow control
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1)
			word_s1 <= in_word;
	end

	rrsm_step u_step (
		.word       (word_s1),
		.cfg        (cfg_q),
		.level      (level_q),
		.door       (door_q),
		.level_next (level_next),
		.door_next  (door_next),
		.brake      (brake)
	);

	// risk level and door timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_NORMAL;
			door_q  <= '0;
		end else if (adv_s1) begin
			level_q <= level_next;
			door_q  <= door_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_word.risk          <= level_next;
			out_word.brake_command <= brake;
		end
	end

	assign out_valid = valid_s2;

	`ASSERT_NOW(a_brake_only_on_auto, out_valid && !is_auto_brake(level_t'(out_word.risk)), out_word.brake_command == BRK_RELEASE, "brake commanded at a warning level")
	`ASSERT_NOW(a_timer_idle_clear, !door_q.timing, door_q.since == '0, "door timer start kept while idle")
	`ASSERT_NEXT(a_state_holds, !adv_s1, $stable(level_q) && $stable(door_q), "state moved without a word")
	`ASSERT_NEXT(a_advance_fills_s2, adv_s1, valid_s2 && out_word.risk == level_q, "result does not match new level")

endmodule

### bench/rollaway_risk_state_machine_top_tb.sv
// self-checking bench for rollaway_risk_state_machine_top: directed vehicle samples,
// then random drive scenarios under several threshold settings, every result word
// checked against a fixed word or a risk-level predictor; depends on rrsm_pkg, top level
`timescale 1ns / 1ps

module rollaway_risk_state_machine_top_tb;
	import rrsm_pkg::*;

	localparam int LIMIT = 200000;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_LEN = 190;
	localparam int REPORT_CAP = 100;

	// codes the package leaves unnamed
	localparam logic [1:0] DRV_OTHER   = 2'd2;
	localparam logic [1:0] DRV_UNKNOWN = 2'd3;
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_INVALID = 2'd3;
	localparam logic [1:0] CFG_NONE    = 2'd3;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	out_word_t out_word;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state and its copy of the registers
	level_t risk_q = LVL_NORMAL;
	logic [31:0] door_since_q = '0;
	bit door_timing_q = 1'b0;
	logic [15:0] speed_thr_q = SPEED_THR_RESET;
	logic [14:0] accel_thr_q = ACCEL_THR_RESET;
	logic [15:0] warn_delay_q = WARN_DELAY_RESET;

	// scenario state of the random drive
	logic [1:0] cur_driver = DRV_ABSENT;
	logic [1:0] cur_gear = GEAR_P;
	bit cur_door = 1'b0;
	logic [31:0] clock_ms = '0;

	out_word_t awaited_verdicts[$];
	probe_t directed_rows[$];
	bit calm = 1'b0;
	int fail_count = 0;
	int samples_sent = 0;
	int verdicts_checked = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int level_hits[8];

	rollaway_risk_state_machine_top dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_word,
		.out_valid,
		.out_stall,
		.out_word,
		.cfg_write,
		.cfg_index,
		.cfg_data
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("rollaway_risk_state_machine_top_tb failed");
			$finish;
		end
	end

	function automatic bit holds_vehicle(level_t lvl);
		return lvl == LVL_DBRAKE || lvl == LVL_RBRAKE || lvl == LVL_RBRK;
	endfunction

	// motion only counts while the actuator feedback is alive
	function automatic bit sample_moving(in_word_t w);
		int ax;
		int ay;
		int t;
		ax = $signed(w.accel_long);
		ay = $signed(w.accel_lat);
		t = int'(accel_thr_q);
		if (!w.actuator_alive)
			return 1'b0;
		if (w.speed >= speed_thr_q)
			return 1'b1;
		return ax >= t || ax <= -t || ay >= t || ay <= -t;
	endfunction

	// priority rules first, then the per-level transitions
	function automatic level_t next_risk(level_t prev, in_word_t w, bit moving,
			logic [31:0] open_ms);
		bit seated;
		bit absent;
		bit door_ajar;
		bit fwd_rev;
		seated = w.driver == DRV_SEATED;
		absent = w.driver == DRV_ABSENT;
		door_ajar = w.door_is_open;
		fwd_rev = w.gear == GEAR_D || w.gear == GEAR_R;
		if (w.gear == GEAR_P && !holds_vehicle(prev))
			return LVL_NORMAL;
		if (seated && !door_ajar)
			return LVL_NORMAL;
		if (w.gear == GEAR_D && absent)
			return LVL_DBRAKE;
		if (w.gear == GEAR_R && absent)
			return LVL_RBRAKE;
		if (w.gear == GEAR_N && moving && absent)
			return LVL_RBRK;
		if (w.gear == GEAR_N && door_ajar)
			return LVL_RWARN;
		case (prev)
			LVL_NORMAL: return (fwd_rev && door_ajar) ? LVL_WARN1 : LVL_NORMAL;
			LVL_WARN1: begin
				if (!door_ajar || !(fwd_rev || w.gear == GEAR_N))
					return LVL_NORMAL;
				return (open_ms >= {16'd0, warn_delay_q}) ? LVL_WARN2 : LVL_WARN1;
			end
			LVL_WARN2: return door_ajar ? LVL_WARN2 : LVL_NORMAL;
			LVL_RWARN: begin
				if (!door_ajar)
					return LVL_NORMAL;
				if (fwd_rev)
					return LVL_WARN1;
				return (moving && absent) ? LVL_RBRK : LVL_RWARN;
			end
			LVL_DBRAKE, LVL_RBRAKE, LVL_RBRK: return prev;
			default: return LVL_NORMAL;
		endcase
	endfunction

	// advances the predictor by one sample and returns the result word
	function automatic out_word_t assess_sample(in_word_t w);
		out_word_t r;
		bit moving;
		bit engaged;
		logic [31:0] open_ms;
		moving = sample_moving(w);
		if (w.door_is_open && !door_timing_q) begin
			door_since_q = w.now_ms;
			door_timing_q = 1'b1;
		end else if (!w.door_is_open) begin
			door_since_q = '0;
			door_timing_q = 1'b0;
		end
		open_ms = door_timing_q ? w.now_ms - door_since_q : 32'd0;
		risk_q = next_risk(risk_q, w, moving, open_ms);
		engaged = w.actuator_alive &&
			(w.actuator_brake == ACT_HOLD || w.actuator_brake == ACT_FORCE);
		r.risk = risk_q;
		if (!holds_vehicle(risk_q))
			r.brake_command = BRK_RELEASE;
		else if (!engaged)
			r.brake_command = BRK_FORCE;
		else
			r.brake_command = BRK_HOLD;
		return r;
	endfunction

	function automatic in_word_t make_sample(logic [1:0] drv, logic [1:0] gear,
			logic door, logic [15:0] spd, logic [15:0] ax, logic [15:0] ay,
			logic alive, logic [1:0] act, logic [31:0] now);
		in_word_t w;
		w.driver = drv;
		w.gear = gear;
		w.door_is_open = door;
		w.speed = spd;
		w.accel_long = ax;
		w.accel_lat = ay;
		w.actuator_alive = alive;
		w.actuator_brake = act;
		w.now_ms = now;
		return w;
	endfunction

	task automatic add_row(in_word_t w, bit typed, level_t lvl, brake_t brk);
		probe_t p;
		p.w = w;
		p.typed = typed;
		p.want.risk = lvl;
		p.want.brake_command = brk;
		directed_rows.push_back(p);
	endtask

	// acceleration near the threshold, zero, small or anything
	function automatic logic [15:0] pick_accel();
		int mag;
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: begin
				mag = int'(accel_thr_q) - int'($urandom_range(0, 1));
				return 16'(($urandom_range(0, 1) == 1) ? -mag : mag);
			end
			2: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 10)) - 5);
		endcase
	endfunction

	// mostly a coherent drive with sticky driver, gear and door; some pure noise
	function automatic in_word_t drive_sample();
		in_word_t w;
		if ($urandom_range(0, 9) == 0) begin
			w.driver = 2'($urandom);
			w.gear = 2'($urandom);
			w.door_is_open = 1'($urandom);
			w.speed = 16'($urandom);
			w.accel_long = 16'($urandom);
			w.accel_lat = 16'($urandom);
			w.actuator_alive = 1'($urandom);
			w.actuator_brake = 2'($urandom);
			w.now_ms = $urandom;
			return w;
		end
		if ($urandom_range(0, 5) == 0)
			cur_driver = 2'($urandom);
		if ($urandom_range(0, 5) == 0)
			cur_gear = 2'($urandom);
		if ($urandom_range(0, 7) == 0)
			cur_door = ~cur_door;
		clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) :
			$urandom_range(20, 80);
		w.driver = cur_driver;
		w.gear = cur_gear;
		w.door_is_open = cur_door;
		case ($urandom_range(0, 3))
			0: w.speed = '0;
			1: w.speed = speed_thr_q - 16'd1 + 16'($urandom_range(0, 2));
			2: w.speed = 16'($urandom);
			default: w.speed = 16'($urandom_range(0, 300));
		endcase
		w.accel_long = pick_accel();
		w.accel_lat = pick_accel();
		w.actuator_alive = ($urandom_range(0, 7) != 0);
		w.actuator_brake = 2'($urandom);
		w.now_ms = clock_ms;
		return w;
	endfunction

	// offer one word, wait for acceptance, then record what should come back
	task automatic send_sample(in_word_t w, bit typed, out_word_t want);
		int gap;
		out_word_t verdict;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		verdict = assess_sample(w);
		awaited_verdicts.push_back(typed ? want : verdict);
		samples_sent++;
	endtask

	task automatic drain_verdicts();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SPEED_THR: speed_thr_q = data;
			CFG_ACCEL_THR: accel_thr_q = data[14:0];
			CFG_WARN_DELAY: warn_delay_q = data;
			default: ;
		endcase
	endtask

	// registers change only with the pipe empty
	task automatic apply_setting(logic [15:0] spd, logic [15:0] acc, logic [15:0] warn);
		drain_verdicts();
		repeat (2) @(posedge clk);
		write_reg(CFG_SPEED_THR, spd);
		write_reg(CFG_ACCEL_THR, acc);
		write_reg(CFG_WARN_DELAY, warn);
		settings_used++;
	endtask

	// result side: random stall per word, check against the oldest expectation
	initial begin
		int hold;
		out_word_t want;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (awaited_verdicts.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_CAP)
					$display("%t unexpected word: risk %0d brake_command %0d",
						$time, out_word.risk, out_word.brake_command);
			end else begin
				want = awaited_verdicts.pop_front();
				if (out_word.risk !== want.risk) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%t risk mismatch: expected %0d got %0d",
							$time, want.risk, out_word.risk);
				end
				if (out_word.brake_command !== want.brake_command) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%t brake_command mismatch: expected %0d got %0d",
							$time, want.brake_command, out_word.brake_command);
				end
				verdicts_checked++;
				level_hits[want.risk]++;
			end
		end
	end

	// stimulus
	initial begin
		// reset thresholds: speed 100, accel 2, door delay 2000 ms
		add_row(make_sample(DRV_SEATED, GEAR_P, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'd0), 1'b1, LVL_NORMAL, BRK_RELEASE);
		// absent driver in drive, brake not engaged yet
		add_row(make_sample(DRV_ABSENT, GEAR_D, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'd50), 1'b1, LVL_DBRAKE, BRK_FORCE);
		add_row(make_sample(DRV_ABSENT, GEAR_D, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_HOLD, 32'd100), 1'b1, LVL_DBRAKE, BRK_HOLD);
		// park does not clear an auto-brake level
		add_row(make_sample(DRV_ABSENT, GEAR_P, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_FORCE, 32'd150), 1'b1, LVL_DBRAKE, BRK_HOLD);
		add_row(make_sample(DRV_SEATED, GEAR_P, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_FORCE, 32'd200), 1'b1, LVL_NORMAL, BRK_RELEASE);
		// dead actuator feedback forces the brake
		add_row(make_sample(DRV_ABSENT, GEAR_R, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			ACT_HOLD, 32'd250), 1'b1, LVL_RBRAKE, BRK_FORCE);
		// field extremes, actuator code 3
		add_row(make_sample(DRV_SEATED, GEAR_D, 1'b0, 16'hFFFF, 16'h7FFF, 16'h8000,
			1'b1, ACT_INVALID, 32'd300), 1'b1, LVL_NORMAL, BRK_RELEASE);
		// door timeout escalates warn1 to warn2 at exactly the delay
		add_row(make_sample(DRV_OTHER, GEAR_D, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'd1000), 1'b1, LVL_WARN1, BRK_RELEASE);
		add_row(make_sample(DRV_OTHER, GEAR_D, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'd2999), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_OTHER, GEAR_D, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'd3000), 1'b0, LVL_NORMAL, BRK_RELEASE);
		// driver code 3 behaves like other
		add_row(make_sample(DRV_UNKNOWN, GEAR_R, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_HOLD, 32'hFFFF_FFFF), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_OTHER, GEAR_D, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'd0), 1'b0, LVL_NORMAL, BRK_RELEASE);
		// door timer across the 32-bit wrap
		add_row(make_sample(DRV_OTHER, GEAR_R, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'hFFFF_FF00), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_OTHER, GEAR_R, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'h0000_0700), 1'b0, LVL_NORMAL, BRK_RELEASE);
		// neutral, absent, speed exactly at threshold
		add_row(make_sample(DRV_ABSENT, GEAR_N, 1'b1, 16'd100, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'h0000_0750), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_SEATED, GEAR_N, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_HOLD, 32'h0000_07A0), 1'b0, LVL_NORMAL, BRK_RELEASE);
		// rollaway warning back to warn1 in drive, then out on door close
		add_row(make_sample(DRV_OTHER, GEAR_D, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'h0000_07F0), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_OTHER, GEAR_N, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'h0000_0840), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_OTHER, GEAR_N, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'h0000_0890), 1'b0, LVL_NORMAL, BRK_RELEASE);
		// motion from lateral accel at minus the threshold
		add_row(make_sample(DRV_ABSENT, GEAR_N, 1'b0, 16'd99, 16'd1, 16'hFFFE, 1'b1,
			ACT_FORCE, 32'h0000_08E0), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_ABSENT, GEAR_N, 1'b0, 16'hFFFF, 16'd0, 16'd0, 1'b0,
			ACT_FORCE, 32'h0000_0930), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_ABSENT, GEAR_N, 1'b0, 16'd99, 16'd1, 16'hFFFF, 1'b1,
			ACT_RELEASE, 32'h0000_0980), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_SEATED, GEAR_N, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_HOLD, 32'h0000_09D0), 1'b1, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_ABSENT, GEAR_N, 1'b0, 16'd99, 16'h8000, 16'd0, 1'b1,
			ACT_HOLD, 32'h0000_0A20), 1'b0, LVL_NORMAL, BRK_RELEASE);
		add_row(make_sample(DRV_SEATED, GEAR_P, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			ACT_RELEASE, 32'h0000_0A70), 1'b1, LVL_NORMAL, BRK_RELEASE);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings_used = 1;

		foreach (directed_rows[i])
			send_sample(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

		// random drive under each threshold setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: apply_setting(16'd0, 16'd0, 16'd0);
				1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: apply_setting(SPEED_THR_RESET, 16'(ACCEL_THR_RESET), WARN_DELAY_RESET);
				3: apply_setting(16'd50, 16'd1, 16'd300);
				default: apply_setting(16'($urandom), 16'($urandom_range(0, 400)),
					16'($urandom_range(0, 5000)));
			endcase
			// index with no register behind it
			if (p == 2)
				write_reg(CFG_NONE, 16'($urandom));
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (k % 32 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (p == 1 && k == PHASE_LEN / 2)
					drain_verdicts();
				send_sample(drive_sample(), 1'b0, '0);
			end
		end

		drain_verdicts();
		repeat (4) @(posedge clk);
		$display("%0d samples over %0d threshold settings, %0d result words checked",
			samples_sent, settings_used, verdicts_checked);
		$display("words per level normal/warn1/warn2/dbrake/rbrake/rwarn/rbrk: %0d %0d %0d %0d %0d %0d %0d",
			level_hits[0], level_hits[1], level_hits[2], level_hits[3],
			level_hits[4], level_hits[5], level_hits[6]);
		if (fail_count == 0 && awaited_verdicts.size() == 0)
			$display("rollaway_risk_state_machine_top_tb passed");
		else
			$display("rollaway_risk_state_machine_top_tb failed");
		$finish;
	end

endmodule

### rollaway_risk_state_machine_top.f
+incdir+src
src/rrsm_pkg.sv
src/rrsm_step.sv
src/rollaway_risk_state_machine_top.sv
bench/rollaway_risk_state_machine_top_tb.sv
